// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DefDepth       = 32;
  localparam int unsigned DefHandleWidth = 8;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned KindW          = 2;
  localparam int unsigned StatusW        = 2;

  typedef enum logic [KindW-1:0] {
    OP_INSERT      = 2'd0,
    OP_EXTRACT     = 2'd1,
    OP_REMOVE      = 2'd2,
    OP_REMOVE_UPTO = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request and register the per-cell compares
    logic apply;      // commit insert / extract / remove and write the result
    logic drop_step;  // pop the head during remove-up-to
    logic finish;     // write the remove-up-to result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic drop_more;  // head present and at or below the bound
  } sts_t;

endpackage

// File: hdl/spq_ctrl.sv
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.op == OP_REMOVE_UPTO) begin
          if (!sts_i.drop_more && out_free) state_d = S_IDLE;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        if (sts_i.op == OP_REMOVE_UPTO) begin
          cmd_o.drop_step = sts_i.drop_more;
          cmd_o.finish    = !sts_i.drop_more && out_free;
        end else begin
          cmd_o.apply = out_free;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/spq_datapath.sv
`timescale 1ns / 1ps
module spq_datapath #(
  parameter int unsigned DEPTH        = spq_pkg::DefDepth,
  parameter int unsigned HANDLE_WIDTH = spq_pkg::DefHandleWidth,
  parameter int unsigned CNT_W        = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_pkg::cmd_t                cmd_i,
  output spq_pkg::sts_t                sts_o,
  input  logic [spq_pkg::KindW-1:0]    kind_i,
  input  logic [spq_pkg::KeyW-1:0]     key_i,
  input  logic [HANDLE_WIDTH-1:0]      handle_i,
  output logic [spq_pkg::StatusW-1:0]  status_o,
  output logic [spq_pkg::KeyW-1:0]     out_key_o,
  output logic [HANDLE_WIDTH-1:0]      out_handle_o,
  output logic [CNT_W-1:0]             removed_count_o,
  output logic [CNT_W-1:0]             occupancy_o
);
  import spq_pkg::*;

  // sorted cell row, slot 0 holds the smallest id
  logic [KeyW-1:0]         key_mem_q [DEPTH];
  logic [KeyW-1:0]         key_mem_d [DEPTH];
  logic [HANDLE_WIDTH-1:0] hnd_mem_q [DEPTH];
  logic [HANDLE_WIDTH-1:0] hnd_mem_d [DEPTH];

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] removed_q, removed_d;

  op_e                     op_q;
  logic [KeyW-1:0]         key_q;
  logic [HANDLE_WIDTH-1:0] hnd_q;
  logic [DEPTH-1:0]        lt_q, eq_q, lt_d, eq_d;

  status_e                 res_status_q, res_status_d;
  logic [KeyW-1:0]         res_key_q, res_key_d;
  logic [HANDLE_WIDTH-1:0] res_hnd_q, res_hnd_d;
  logic [CNT_W-1:0]        res_removed_q, res_removed_d;
  logic [CNT_W-1:0]        res_occ_q, res_occ_d;

  logic                    found, full, empty;
  logic [KeyW-1:0]         match_key;
  logic [HANDLE_WIDTH-1:0] match_hnd;

  // per-cell compare against the incoming id, only for occupied cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_d[i] = (CNT_W'(i) < cnt_q) && (key_mem_q[i] < key_i);
      eq_d[i] = (CNT_W'(i) < cnt_q) && (key_mem_q[i] == key_i);
    end
  end

  assign found   = |eq_q;
  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);

  // ids are unique, so at most one eq bit is set
  always_comb begin
    match_key = '0;
    match_hnd = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq_q[i]) begin
        match_key = match_key | key_mem_q[i];
        match_hnd = match_hnd | hnd_mem_q[i];
      end
    end
  end

  always_comb begin
    key_mem_d     = key_mem_q;
    hnd_mem_d     = hnd_mem_q;
    cnt_d         = cnt_q;
    removed_d     = removed_q;
    res_status_d  = res_status_q;
    res_key_d     = res_key_q;
    res_hnd_d     = res_hnd_q;
    res_removed_d = res_removed_q;
    res_occ_d     = res_occ_q;

    if (cmd_i.capture) begin
      removed_d = '0;
    end

    if (cmd_i.apply) begin
      res_status_d  = ST_OK;
      res_key_d     = '0;
      res_hnd_d     = '0;
      res_removed_d = '0;
      unique case (op_q)
        OP_INSERT: begin
          if (found) begin
            res_status_d = ST_DUP;
          end else if (full) begin
            res_status_d = ST_FULL;
          end else begin
            // cells below the slot keep, the slot takes the new entry,
            // cells above move up by one
            if (!lt_q[0]) begin
              key_mem_d[0] = key_q;
              hnd_mem_d[0] = hnd_q;
            end
            for (int i = 1; i < DEPTH; i++) begin
              if (!lt_q[i]) begin
                if (lt_q[i-1]) begin
                  key_mem_d[i] = key_q;
                  hnd_mem_d[i] = hnd_q;
                end else begin
                  key_mem_d[i] = key_mem_q[i-1];
                  hnd_mem_d[i] = hnd_mem_q[i-1];
                end
              end
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_EXTRACT: begin
          if (empty) begin
            res_status_d = ST_MISS;
          end else begin
            res_key_d = key_mem_q[0];
            res_hnd_d = hnd_mem_q[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
              key_mem_d[i] = key_mem_q[i+1];
              hnd_mem_d[i] = hnd_mem_q[i+1];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!found) begin
            res_status_d = ST_MISS;
          end else begin
            res_key_d = match_key;
            res_hnd_d = match_hnd;
            // the match and everything above it move down by one
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (!lt_q[i]) begin
                key_mem_d[i] = key_mem_q[i+1];
                hnd_mem_d[i] = hnd_mem_q[i+1];
              end
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_REMOVE_UPTO: begin
          res_status_d = ST_OK;
        end
        default: begin
          res_status_d = ST_OK;
        end
      endcase
      res_occ_d = cnt_d;
    end

    if (cmd_i.drop_step) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        key_mem_d[i] = key_mem_q[i+1];
        hnd_mem_d[i] = hnd_mem_q[i+1];
      end
      cnt_d     = cnt_q - 1'b1;
      removed_d = removed_q + 1'b1;
    end

    if (cmd_i.finish) begin
      res_status_d  = ST_OK;
      res_key_d     = '0;
      res_hnd_d     = '0;
      res_removed_d = removed_q;
      res_occ_d     = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      removed_q <= '0;
      op_q      <= OP_INSERT;
    end else begin
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      if (cmd_i.capture) op_q <= op_e'(kind_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_mem_q     <= key_mem_d;
    hnd_mem_q     <= hnd_mem_d;
    res_status_q  <= res_status_d;
    res_key_q     <= res_key_d;
    res_hnd_q     <= res_hnd_d;
    res_removed_q <= res_removed_d;
    res_occ_q     <= res_occ_d;
    if (cmd_i.capture) begin
      key_q <= key_i;
      hnd_q <= handle_i;
      lt_q  <= lt_d;
      eq_q  <= eq_d;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.drop_more = !empty && (key_mem_q[0] <= key_q);

  assign status_o        = res_status_q;
  assign out_key_o       = res_key_q;
  assign out_handle_o    = res_hnd_q;
  assign removed_count_o = res_removed_q;
  assign occupancy_o     = res_occ_q;

endmodule

// File: hdl/sorted_packet_id_queue.sv
`timescale 1ns / 1ps
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o   | kind_i, key_i, handle_i
// out     | output    | out_valid_o / out_stall_i | status_o, out_key_o, out_handle_o,
//         |           |                           | removed_count_o, occupancy_o
//
// Insert, extract and remove: the accepting edge registers a compare per cell; once the result
// register is free, the cell row shifts and the result register loads.
// Remove-up-to: the head is popped one per cycle while it is at or below the bound.
// Reset (rst_ni low, asynchronous) empties the queue and the output register; cell
// contents stay as they are and are never read until written.
// A stalled result holds the next accepted transfer before commit until the register frees.
module sorted_packet_id_queue #(
  parameter int unsigned DEPTH        = spq_pkg::DefDepth,
  parameter int unsigned HANDLE_WIDTH = spq_pkg::DefHandleWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input transfer
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [spq_pkg::KindW-1:0]       kind_i,
  input  logic [spq_pkg::KeyW-1:0]        key_i,
  input  logic [HANDLE_WIDTH-1:0]         handle_i,
  // result transfer
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spq_pkg::StatusW-1:0]     status_o,
  output logic [spq_pkg::KeyW-1:0]        out_key_o,
  output logic [HANDLE_WIDTH-1:0]         out_handle_o,
  output logic [$clog2(DEPTH + 1)-1:0]    removed_count_o,
  output logic [$clog2(DEPTH + 1)-1:0]    occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / execute, owns both handshakes and the output valid
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // sorted cell row, per-cell comparators, occupancy and the result register
  spq_datapath #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .CNT_W        (CntW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .handle_i        (handle_i),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_handle_o    (out_handle_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// File: hdl/spq_checker.sv
`timescale 1ns / 1ps
module spq_checker #(
  parameter int unsigned DEPTH        = spq_pkg::DefDepth,
  parameter int unsigned HANDLE_WIDTH = spq_pkg::DefHandleWidth
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [spq_pkg::KindW-1:0]       kind_i,
  input logic [spq_pkg::KeyW-1:0]        key_i,
  input logic [HANDLE_WIDTH-1:0]         handle_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [spq_pkg::StatusW-1:0]     status_o,
  input logic [spq_pkg::KeyW-1:0]        out_key_o,
  input logic [HANDLE_WIDTH-1:0]         out_handle_o,
  input logic [$clog2(DEPTH + 1)-1:0]    removed_count_o,
  input logic [$clog2(DEPTH + 1)-1:0]    occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic unused_in;
  assign unused_in = ^{in_valid_i, in_stall_o, kind_i, key_i, handle_i};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(out_key_o)
      && $stable(out_handle_o) && $stable(removed_count_o) && $stable(occupancy_o))
    else $error("result payload changed while stalled");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= CntW'(DEPTH))
    else $error("occupancy above depth");

  // failed operations carry no entry and no drop count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      out_key_o == '0 && out_handle_o == '0 && removed_count_o == '0)
    else $error("failed operation reports an entry");

  // drops only come from remove-up-to, which reports no entry
  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != '0 |->
      status_o == ST_OK && out_key_o == '0 && out_handle_o == '0)
    else $error("drop count with inconsistent result");

endmodule

bind sorted_packet_id_queue spq_checker #(
  .DEPTH        (DEPTH),
  .HANDLE_WIDTH (HANDLE_WIDTH)
) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .kind_i          (kind_i),
  .key_i           (key_i),
  .handle_i        (handle_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .out_key_o       (out_key_o),
  .out_handle_o    (out_handle_o),
  .removed_count_o (removed_count_o),
  .occupancy_o     (occupancy_o)
);
